>>> src/utf8dw_pkg.sv
// Shared types, constants and decode/cluster functions for the UTF-8 display width counter.
package utf8dw_pkg;

	localparam int unsigned TotalW = 31;
	localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
	localparam int unsigned CpW = 21;
	localparam int unsigned Slots = 4;

	localparam logic [CpW-1:0] CpZwj       = 21'h0200d;
	localparam logic [CpW-1:0] CpVs16      = 21'h0fe0f;
	localparam logic [CpW-1:0] CpKeycap    = 21'h020e3;
	localparam logic [CpW-1:0] CpRegionLo  = 21'h1f1e6;
	localparam logic [CpW-1:0] CpRegionHi  = 21'h1f1ff;
	localparam logic [CpW-1:0] CpPictLo    = 21'h1f000;
	localparam logic [CpW-1:0] CpPictHi    = 21'h1faff;
	localparam logic [7:0]     ContMask    = 8'hc0;
	localparam logic [7:0]     ContPattern = 8'h80;

	localparam int unsigned EmojiRanges = 33;
	localparam logic [15:0] EmojiTab [EmojiRanges][2] = '{
		'{16'h231a, 16'h231b}, '{16'h23e9, 16'h23ec}, '{16'h23f0, 16'h23f0},
		'{16'h23f3, 16'h23f3}, '{16'h25fd, 16'h25fe}, '{16'h2614, 16'h2615},
		'{16'h2648, 16'h2653}, '{16'h267f, 16'h267f}, '{16'h2693, 16'h2693},
		'{16'h26a1, 16'h26a1}, '{16'h26aa, 16'h26ab}, '{16'h26bd, 16'h26be},
		'{16'h26c4, 16'h26c5}, '{16'h26ce, 16'h26ce}, '{16'h26d4, 16'h26d4},
		'{16'h26ea, 16'h26ea}, '{16'h26f2, 16'h26f3}, '{16'h26f5, 16'h26f5},
		'{16'h26fa, 16'h26fa}, '{16'h26fd, 16'h26fd}, '{16'h2705, 16'h2705},
		'{16'h270a, 16'h270b}, '{16'h2728, 16'h2728}, '{16'h274c, 16'h274c},
		'{16'h274e, 16'h274e}, '{16'h2753, 16'h2755}, '{16'h2757, 16'h2757},
		'{16'h2795, 16'h2797}, '{16'h27b0, 16'h27b0}, '{16'h27bf, 16'h27bf},
		'{16'h2b1b, 16'h2b1c}, '{16'h2b50, 16'h2b50}, '{16'h2b55, 16'h2b55}
	};

	// Code points decoded from one byte window, one slot per decode step
	typedef struct packed {
		logic [Slots-1:0]          vld;
		logic [Slots-1:0]          single;
		logic [Slots-1:0][CpW-1:0] cp;
	} cp_list_t;

	typedef struct packed {
		cp_list_t        cps;
		logic [2:0][7:0] rem_bytes;
		logic [1:0]      rem_cnt;
	} dec_t;

	// Open cluster state
	typedef struct packed {
		logic       open;
		logic       first_reg;
		logic       join_p;
		logic       pair_closed;
		logic [1:0] width;
		logic       emoji;
		logic       ctrl;
		logic       stopped;
	} cl_t;

	typedef struct packed {
		cl_t        st;
		logic [1:0] add;
	} feed_t;

	function automatic logic in_rng(input logic [CpW-1:0] c, input logic [CpW-1:0] lo,
		input logic [CpW-1:0] hi);
		return (c >= lo) && (c <= hi);
	endfunction

	function automatic logic wide_cp(input logic [CpW-1:0] c);
		return in_rng(c, 21'h01100, 21'h0115f) || in_rng(c, 21'h02329, 21'h0232a) ||
			in_rng(c, 21'h02e80, 21'h0a4cf) || in_rng(c, 21'h0ac00, 21'h0d7a3) ||
			in_rng(c, 21'h0f900, 21'h0faff) || in_rng(c, 21'h0fe10, 21'h0fe19) ||
			in_rng(c, 21'h0fe30, 21'h0fe6f) || in_rng(c, 21'h0ff00, 21'h0ff60) ||
			in_rng(c, 21'h0ffe0, 21'h0ffe6) || in_rng(c, CpPictLo, CpPictHi);
	endfunction

	function automatic logic zero_cp(input logic [CpW-1:0] c);
		return in_rng(c, 21'h00300, 21'h0036f) || in_rng(c, 21'h01ab0, 21'h01aff) ||
			in_rng(c, 21'h01dc0, 21'h01dff) || in_rng(c, 21'h020d0, 21'h020ff) ||
			in_rng(c, 21'h0fe20, 21'h0fe2f) || in_rng(c, 21'h0fe00, 21'h0fe0f) ||
			in_rng(c, 21'he0100, 21'he01ef) || in_rng(c, 21'he0020, 21'he007f) ||
			in_rng(c, 21'h1f3fb, 21'h1f3ff) || (c == CpZwj);
	endfunction

	function automatic logic regional_cp(input logic [CpW-1:0] c);
		return in_rng(c, CpRegionLo, CpRegionHi);
	endfunction

	function automatic logic emoji_cp(input logic [CpW-1:0] c);
		logic hit;
		hit = (c == CpVs16) || (c == CpZwj) || (c == CpKeycap) || in_rng(c, CpPictLo, CpPictHi);
		for (int k = 0; k < EmojiRanges; k++) begin
			if (c[CpW-1:16] == '0 && c[15:0] >= EmojiTab[k][0] && c[15:0] <= EmojiTab[k][1])
				hit = 1'b1;
		end
		return hit;
	endfunction

	// Split a byte window into code points; a stalled partial sequence is left over
	function automatic dec_t utf8_decode(input logic [3:0][7:0] bytes, input logic [2:0] n,
		input logic fin);
		dec_t       r;
		logic [2:0] p;
		logic       done;
		logic [7:0] lead;
		logic [2:0] need;
		logic [2:0] left;
		logic       bad;
		logic [2:0] idx;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [2:0] p1;
		logic [2:0] p2;
		logic [2:0] p3;
		r = '0;
		p = '0;
		done = 1'b0;
		for (int it = 0; it < Slots; it++) begin
			if (!done && p < n) begin
				lead = bytes[p[1:0]];
				if (lead < 8'h80) need = 3'd1;
				else if ((lead & 8'he0) == 8'hc0) need = 3'd2;
				else if ((lead & 8'hf0) == 8'he0) need = 3'd3;
				else if ((lead & 8'hf8) == 8'hf0) need = 3'd4;
				else need = 3'd0;
				left = n - p;
				p1 = p + 3'd1;
				p2 = p + 3'd2;
				p3 = p + 3'd3;
				b1 = bytes[p1[1:0]];
				b2 = bytes[p2[1:0]];
				b3 = bytes[p3[1:0]];
				if (need <= 3'd1) begin
					r.cps.vld[it] = 1'b1;
					r.cps.single[it] = 1'b1;
					r.cps.cp[it] = {13'd0, lead};
					p = p1;
				end else begin
					bad = 1'b0;
					for (int i = 1; i < 4; i++) begin
						idx = p + 3'(i);
						if (3'(i) < need && 3'(i) < left &&
							(bytes[idx[1:0]] & ContMask) != ContPattern)
							bad = 1'b1;
					end
					if (bad || (left < need && fin)) begin
						r.cps.vld[it] = 1'b1;
						r.cps.single[it] = 1'b1;
						r.cps.cp[it] = {13'd0, lead};
						p = p1;
					end else if (left >= need) begin
						r.cps.vld[it] = 1'b1;
						r.cps.single[it] = 1'b0;
						if (need == 3'd2)
							r.cps.cp[it] = {10'd0, lead[4:0], b1[5:0]};
						else if (need == 3'd3)
							r.cps.cp[it] = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
						else
							r.cps.cp[it] = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
						p = p + need;
					end else begin
						done = 1'b1;
					end
				end
			end
		end
		// leftover bytes of an unfinished sequence
		for (int j = 0; j < 3; j++) begin
			idx = p + 3'(j);
			r.rem_bytes[j] = (idx < n) ? bytes[idx[1:0]] : 8'd0;
		end
		left = n - p;
		r.rem_cnt = left[1:0];
		return r;
	endfunction

	function automatic cl_t absorb(input cl_t s, input logic [CpW-1:0] c);
		cl_t        r;
		logic [1:0] w;
		r = s;
		if (emoji_cp(c))
			r.emoji = 1'b1;
		if (!zero_cp(c)) begin
			w = wide_cp(c) ? 2'd2 : 2'd1;
			if (w > r.width)
				r.width = w;
		end
		return r;
	endfunction

	function automatic logic [1:0] close_w(input cl_t s);
		logic [1:0] w;
		if (!s.open) w = 2'd0;
		else if (s.ctrl) w = 2'd1;
		else if (s.emoji && s.width == 2'd1) w = 2'd2;
		else w = s.width;
		return w;
	endfunction

	function automatic cl_t open_cl(input cl_t s, input logic [CpW-1:0] c, input logic single);
		cl_t r;
		r = s;
		if (single && c == '0) begin
			r.stopped = 1'b1;
			r.open = 1'b0;
		end else begin
			r.open = 1'b1;
			r.first_reg = regional_cp(c);
			r.join_p = 1'b0;
			r.pair_closed = 1'b0;
			r.width = 2'd0;
			r.emoji = 1'b0;
			r.ctrl = single && (c == 21'd10 || c == 21'd13 || c == 21'd9);
			r = absorb(r, c);
		end
		return r;
	endfunction

	// One code point into the cluster segmenter
	function automatic feed_t feed(input cl_t s, input logic [CpW-1:0] c, input logic single);
		feed_t r;
		r.st = s;
		r.add = 2'd0;
		if (!s.stopped) begin
			if (!s.open) begin
				r.st = open_cl(s, c, single);
			end else if (s.pair_closed) begin
				r.add = close_w(s);
				r.st = open_cl(s, c, single);
			end else if (s.join_p) begin
				r.st = absorb(s, c);
				r.st.join_p = 1'b0;
			end else if (c == CpZwj) begin
				r.st = absorb(s, c);
				r.st.join_p = 1'b1;
			end else if (zero_cp(c)) begin
				r.st = absorb(s, c);
			end else if (s.first_reg && regional_cp(c)) begin
				r.st = absorb(s, c);
				r.st.pair_closed = 1'b1;
			end else begin
				r.add = close_w(s);
				r.st = open_cl(s, c, single);
			end
		end
		return r;
	endfunction

endpackage

>>> src/utf8dw_decode.sv
// UTF-8 byte decoder: holds the bytes of an unfinished sequence and emits code points.
module utf8dw_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          data_byte,
	input  logic                last,
	output utf8dw_pkg::cp_list_t cps
);
	import utf8dw_pkg::*;

	logic [2:0][7:0] pend_q;
	logic [1:0]      pend_cnt_q;
	logic [3:0][7:0] window;
	dec_t            dec;

	// pending bytes followed by the new byte
	always_comb begin
		window = {data_byte, pend_q};
		window[pend_cnt_q] = data_byte;
		dec = utf8_decode(window, {1'b0, pend_cnt_q} + 3'd1, last);
	end

	assign cps = dec.cps;

	// leftover sequence; cleared at the end of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
		end else if (advance) begin
			pend_cnt_q <= last ? 2'd0 : dec.rem_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			pend_q <= dec.rem_bytes;
	end

endmodule

>>> src/utf8dw_cluster.sv
// Cluster segmenter and saturating width accumulator.
module utf8dw_cluster (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        last,
	input  utf8dw_pkg::cp_list_t        cps,
	output logic [utf8dw_pkg::TotalW-1:0] total
);
	import utf8dw_pkg::*;

	cl_t              st_q;
	logic [TotalW-1:0] total_q;
	cl_t              st_n;
	feed_t            fr;
	logic [3:0]       inc;
	logic [TotalW:0]  sum;

	// run each decoded code point through the segmenter in order
	always_comb begin
		st_n = st_q;
		inc = '0;
		for (int i = 0; i < Slots; i++) begin
			fr = feed(st_n, cps.cp[i], cps.single[i]);
			if (cps.vld[i]) begin
				st_n = fr.st;
				inc = inc + 4'(fr.add);
			end
		end
		if (last)
			inc = inc + 4'(close_w(st_n));
		sum = {1'b0, total_q} + (TotalW + 1)'(inc);
		total = sum[TotalW] ? TotalMax : sum[TotalW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			total_q <= '0;
		end else if (advance) begin
			st_q <= last ? cl_t'('0) : st_n;
			total_q <= last ? '0 : total;
		end
	end

endmodule

>>> src/utf8_display_width_counter.sv
// Top level of the UTF-8 display width counter.
// Takes one byte of UTF-8 text per cycle; the byte flagged last yields one transaction
// carrying the text's total display width (saturating at 2^31-1). Each byte passes an
// input register and is then decoded, segmented and summed, so a byte can be accepted every
// cycle unless stalled. The result sits in an output register, so input only stalls when
// a last byte meets a result that is still held by out_stall. Logic state returns to reset
// after each text.
module utf8_display_width_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] display_width
);
	import utf8dw_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	cp_list_t          cps;
	logic [TotalW-1:0] total;
	logic              out_valid_q;
	logic [TotalW-1:0] width_q;

	// a byte moves on unless it is a last byte blocked by a held result
	assign advance  = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	utf8dw_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.last      (last_s1),
		.cps       (cps)
	);

	utf8dw_cluster u_cluster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.last    (last_s1),
		.cps     (cps),
		.total   (total)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			width_q <= total;
	end

	assign out_valid     = out_valid_q;
	assign display_width = width_q;

	// a byte that is not last never waits
	a_mid_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_s1 |-> !in_stall)
		else $error("non-final byte stalled");

	// a new result only follows a last byte
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && last_s1))
		else $error("result without last byte");

	// a held result blocks the next last byte
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && valid_s1 && last_s1 |=> out_valid)
		else $error("held result dropped");

endmodule
